[rtl/savc_pkg.sv]
`timescale 1ns / 1ps
// savc_pkg: shared types, codes and default sizes of the cache block
// no dependencies; used by every file under rtl

package savc_pkg;

    // default geometry
    localparam int OFFSET_BITS_DEF    = 5;
    localparam int INDEX_BITS_DEF     = 6;
    localparam int WAYS_DEF           = 4;
    localparam int VICTIM_ENTRIES_DEF = 4;

    // access kinds
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // result word kinds
    localparam logic [1:0] KIND_STATUS    = 2'd0;
    localparam logic [1:0] KIND_WRITEBACK = 2'd1;
    localparam logic [1:0] KIND_FETCH     = 2'd2;

    // hit status codes
    localparam logic [1:0] HIT_MISS   = 2'd0;
    localparam logic [1:0] HIT_MAIN   = 2'd1;
    localparam logic [1:0] HIT_VICTIM = 2'd2;

    // access request word
    typedef struct packed {
        logic        command;
        logic [31:0] address;
    } req_t;

    // result word
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] mem_address;
        logic [1:0]  hit_status;
        logic        last;
    } rsp_t;

    // victim buffer lookup flags
    typedef struct packed {
        logic hit;
        logic hit_dirty;
        logic lru_valid;
        logic lru_dirty;
    } vb_status_t;

    // victim buffer entry write
    typedef struct packed {
        logic we;
        logic valid;
        logic dirty;
    } vb_update_t;

endpackage

[rtl/savc_tag_ram.sv]
`timescale 1ns / 1ps
// savc_tag_ram: one row per set holding tag, valid, dirty and age of every way
// depends on savc_pkg; synchronous memory with a registered read

module savc_tag_ram
    import savc_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF,
    parameter int WAYS       = WAYS_DEF,
    parameter int TAG_W      = 32 - OFFSET_BITS_DEF - INDEX_BITS_DEF
)
(
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           rd_en,
    input  logic [((INDEX_BITS > 0) ? INDEX_BITS : 1)-1:0] rd_set,
    output logic [WAYS*(TAG_W+2+((WAYS > 1) ? $clog2(WAYS) : 1))-1:0] rd_row,
    input  logic                                           wr_en,
    input  logic [((INDEX_BITS > 0) ? INDEX_BITS : 1)-1:0] wr_set,
    input  logic [WAYS*(TAG_W+2+((WAYS > 1) ? $clog2(WAYS) : 1))-1:0] wr_row
);

    localparam int NSETS = 1 << INDEX_BITS;
    localparam int AGE_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ENT_W = TAG_W + 2 + AGE_W;
    localparam int ROW_W = WAYS * ENT_W;

    logic [ROW_W-1:0] row_mem [NSETS];
    logic [NSETS-1:0] row_valid_reg;
    logic [ROW_W-1:0] rd_data_reg;
    logic             rd_valid_reg;
    logic [ROW_W-1:0] reset_row;

    // memory array, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            row_mem[wr_set] <= wr_row;
        end
        if (rd_en)
        begin
            rd_data_reg <= row_mem[rd_set];
        end
    end

    // per-set written marks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_valid_reg[wr_set] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= row_valid_reg[rd_set];
            end
        end
    end

    // row seen before first write: invalid, clean, age equals way
    always_comb
    begin
        reset_row = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            reset_row[w*ENT_W +: AGE_W] = AGE_W'(w);
        end
    end

    assign rd_row = rd_valid_reg ? rd_data_reg : reset_row;

endmodule

[rtl/savc_victim_buf.sv]
`timescale 1ns / 1ps
// savc_victim_buf: fully associative victim entries with lru ages
// depends on savc_pkg; entries held in flops, searched in parallel

module savc_victim_buf
    import savc_pkg::*;
#(
    parameter int BLK_W          = 32 - OFFSET_BITS_DEF,
    parameter int VICTIM_ENTRIES = VICTIM_ENTRIES_DEF
)
(
    input  logic                                                        clk,
    input  logic                                                        rst_n,
    input  logic [BLK_W-1:0]                                            look_blk,
    output vb_status_t                                                  status,
    output logic [((VICTIM_ENTRIES > 1) ? $clog2(VICTIM_ENTRIES) : 1)-1:0] hit_idx,
    output logic [((VICTIM_ENTRIES > 1) ? $clog2(VICTIM_ENTRIES) : 1)-1:0] lru_idx,
    output logic [BLK_W-1:0]                                            lru_addr,
    input  vb_update_t                                                  upd,
    input  logic [((VICTIM_ENTRIES > 1) ? $clog2(VICTIM_ENTRIES) : 1)-1:0] upd_idx,
    input  logic [BLK_W-1:0]                                            upd_addr
);

    localparam int IDX_W = (VICTIM_ENTRIES > 1) ? $clog2(VICTIM_ENTRIES) : 1;

    logic [BLK_W-1:0]          addr_reg  [VICTIM_ENTRIES];
    logic [VICTIM_ENTRIES-1:0] valid_reg;
    logic [VICTIM_ENTRIES-1:0] dirty_reg;
    logic [IDX_W-1:0]          age_reg   [VICTIM_ENTRIES];

    // parallel search, lru is the entry holding the top age
    always_comb
    begin
        status  = '0;
        hit_idx = '0;
        lru_idx = '0;
        for (int e = 0; e < VICTIM_ENTRIES; e++)
        begin
            if (valid_reg[e] && addr_reg[e] == look_blk)
            begin
                status.hit = 1'b1;
                hit_idx    = IDX_W'(e);
            end
            if (age_reg[e] == IDX_W'(VICTIM_ENTRIES - 1))
            begin
                lru_idx = IDX_W'(e);
            end
        end
        status.hit_dirty = dirty_reg[hit_idx];
        status.lru_valid = valid_reg[lru_idx];
        status.lru_dirty = dirty_reg[lru_idx];
        lru_addr         = addr_reg[lru_idx];
    end

    // entry payload
    always_ff @(posedge clk)
    begin
        if (upd.we)
        begin
            addr_reg[upd_idx] <= upd_addr;
        end
    end

    // flags and ages, written entry becomes most recent
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            dirty_reg <= '0;
            for (int e = 0; e < VICTIM_ENTRIES; e++)
            begin
                age_reg[e] <= IDX_W'(e);
            end
        end
        else if (upd.we)
        begin
            valid_reg[upd_idx] <= upd.valid;
            dirty_reg[upd_idx] <= upd.dirty;
            for (int e = 0; e < VICTIM_ENTRIES; e++)
            begin
                if (IDX_W'(e) == upd_idx)
                begin
                    age_reg[e] <= '0;
                end
                else if (age_reg[e] < age_reg[upd_idx])
                begin
                    age_reg[e] <= age_reg[e] + 1'b1;
                end
            end
        end
    end

endmodule

[rtl/set_assoc_cache_with_victim_buffer_top.sv]
`timescale 1ns / 1ps
// set_assoc_cache_with_victim_buffer_top: access sequencer of the cache
// depends on savc_pkg, savc_tag_ram, savc_victim_buf
//
// channel   | ports                       | handshake
// ----------+-----------------------------+-------------------------------
// request   | start, busy, req            | taken when start and not busy
// result    | rsp_valid, rsp              | one word per cycle, no stall
// config    | cfg_wr_en, cfg_wr_data      | written whenever cfg_wr_en high
//
// a hit steps through set row read, lookup and row write-back, status word
// a miss adds a fetch word, with a writeback word ahead of it for a dirty line
// the steps are set by the registered tag row read ahead of its write-back
// busy stays high from acceptance until the status word has been shown
// reset leaves all lines and victim entries invalid with no clearing pass

module set_assoc_cache_with_victim_buffer_top
    import savc_pkg::*;
#(
    parameter int OFFSET_BITS    = OFFSET_BITS_DEF,
    parameter int INDEX_BITS     = INDEX_BITS_DEF,
    parameter int WAYS           = WAYS_DEF,
    parameter int VICTIM_ENTRIES = VICTIM_ENTRIES_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t req,
    output logic rsp_valid,
    output rsp_t rsp,
    input  logic cfg_wr_en,
    input  logic cfg_wr_data
);

    localparam int NSETS = 1 << INDEX_BITS;
    localparam int SET_W = (INDEX_BITS > 0) ? INDEX_BITS : 1;
    localparam int TAG_W = 32 - OFFSET_BITS - INDEX_BITS;
    localparam int BLK_W = 32 - OFFSET_BITS;
    localparam int AGE_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ENT_W = TAG_W + 2 + AGE_W;
    localparam int ROW_W = WAYS * ENT_W;
    localparam int VIDX_W = (VICTIM_ENTRIES > 1) ? $clog2(VICTIM_ENTRIES) : 1;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_LOOKUP = 3'b010,
        ST_EMIT   = 3'b100
    } state_t;

    state_t state_reg, state_next;
    req_t   req_reg;
    logic   victim_enable_reg;
    logic   wb_pend_reg, wb_pend_next;
    logic   fe_pend_reg, fe_pend_next;
    logic [31:0] wb_addr_reg, wb_addr_next;
    logic [31:0] fe_addr_reg, fe_addr_next;
    logic [1:0]  status_reg, status_next;

    logic             accept;
    logic [SET_W-1:0] rd_set;
    logic [ROW_W-1:0] rd_row;
    logic [ROW_W-1:0] wr_row;
    logic             wr_en;

    logic [BLK_W-1:0] blk;
    logic [BLK_W-1:0] set_blk;
    logic [SET_W-1:0] set_idx;
    logic [TAG_W-1:0] tag;

    logic [TAG_W-1:0] e_tag   [WAYS];
    logic             e_valid [WAYS];
    logic             e_dirty [WAYS];
    logic [AGE_W-1:0] e_age   [WAYS];
    logic [TAG_W-1:0] n_tag   [WAYS];
    logic             n_valid [WAYS];
    logic             n_dirty [WAYS];
    logic [AGE_W-1:0] n_age   [WAYS];

    logic             hit;
    logic [AGE_W-1:0] hit_way;
    logic [AGE_W-1:0] lru_way;
    logic [AGE_W-1:0] pick;
    logic [AGE_W-1:0] pick_age;
    logic             vhit_use;
    logic [BLK_W-1:0] old_blk;

    vb_status_t        vb_st;
    vb_update_t        vb_upd;
    logic [VIDX_W-1:0] vb_hit_idx;
    logic [VIDX_W-1:0] vb_lru_idx;
    logic [VIDX_W-1:0] vb_upd_idx;
    logic [BLK_W-1:0]  vb_lru_addr;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign rd_set = SET_W'((req.address >> OFFSET_BITS) & 32'(NSETS - 1));

    // set rows
    savc_tag_ram #(
        .INDEX_BITS (INDEX_BITS),
        .WAYS       (WAYS),
        .TAG_W      (TAG_W)
    ) u_tag_ram (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_en  (accept),
        .rd_set (rd_set),
        .rd_row (rd_row),
        .wr_en  (wr_en),
        .wr_set (set_idx),
        .wr_row (wr_row)
    );

    // victim entries
    savc_victim_buf #(
        .BLK_W          (BLK_W),
        .VICTIM_ENTRIES (VICTIM_ENTRIES)
    ) u_victim_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .look_blk (blk),
        .status   (vb_st),
        .hit_idx  (vb_hit_idx),
        .lru_idx  (vb_lru_idx),
        .lru_addr (vb_lru_addr),
        .upd      (vb_upd),
        .upd_idx  (vb_upd_idx),
        .upd_addr (old_blk)
    );

    // address split of the held access
    assign blk     = req_reg.address[31:OFFSET_BITS];
    assign set_blk = blk & BLK_W'(NSETS - 1);
    assign set_idx = SET_W'(set_blk);
    assign tag     = req_reg.address[31 -: TAG_W];

    // row unpack, tag compare and lru pick
    always_comb
    begin
        hit     = 1'b0;
        hit_way = '0;
        lru_way = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            e_age[w]   = rd_row[w*ENT_W +: AGE_W];
            e_dirty[w] = rd_row[w*ENT_W + AGE_W];
            e_valid[w] = rd_row[w*ENT_W + AGE_W + 1];
            e_tag[w]   = rd_row[w*ENT_W + AGE_W + 2 +: TAG_W];
            if (e_valid[w] && e_tag[w] == tag)
            begin
                hit     = 1'b1;
                hit_way = AGE_W'(w);
            end
            if (e_age[w] == AGE_W'(WAYS - 1))
            begin
                lru_way = AGE_W'(w);
            end
        end
        old_blk  = (BLK_W'(e_tag[lru_way]) << INDEX_BITS) | set_blk;
        vhit_use = !hit && victim_enable_reg && vb_st.hit;
        pick     = hit ? hit_way : lru_way;
        pick_age = e_age[pick];
    end

    // new row contents
    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            n_tag[w]   = e_tag[w];
            n_valid[w] = e_valid[w];
            n_dirty[w] = e_dirty[w];
            n_age[w]   = (e_age[w] < pick_age) ? e_age[w] + 1'b1 : e_age[w];
        end
        n_age[pick] = '0;
        if (hit)
        begin
            n_dirty[pick] = e_dirty[pick] || (req_reg.command == CMD_WRITE);
        end
        else
        begin
            n_tag[pick]   = tag;
            n_valid[pick] = 1'b1;
            n_dirty[pick] = (vhit_use && vb_st.hit_dirty) || (req_reg.command == CMD_WRITE);
        end
        for (int w = 0; w < WAYS; w++)
        begin
            wr_row[w*ENT_W +: ENT_W] = {n_tag[w], n_valid[w], n_dirty[w], n_age[w]};
        end
    end

    assign wr_en = (state_reg == ST_LOOKUP);

    // victim swap or fill with the displaced line
    always_comb
    begin
        vb_upd.we    = wr_en && (vhit_use || (!hit && victim_enable_reg && e_valid[lru_way]));
        vb_upd.valid = e_valid[lru_way];
        vb_upd.dirty = e_dirty[lru_way];
        vb_upd_idx   = vhit_use ? vb_hit_idx : vb_lru_idx;
    end

    // pending result words
    always_comb
    begin
        wb_pend_next = wb_pend_reg;
        fe_pend_next = fe_pend_reg;
        wb_addr_next = wb_addr_reg;
        fe_addr_next = fe_addr_reg;
        status_next  = status_reg;
        if (state_reg == ST_LOOKUP)
        begin
            fe_pend_next = !hit && !vhit_use;
            fe_addr_next = {blk, OFFSET_BITS'(0)};
            if (victim_enable_reg)
            begin
                wb_pend_next = !hit && !vhit_use && e_valid[lru_way]
                               && vb_st.lru_valid && vb_st.lru_dirty;
                wb_addr_next = {vb_lru_addr, OFFSET_BITS'(0)};
            end
            else
            begin
                wb_pend_next = !hit && e_valid[lru_way] && e_dirty[lru_way];
                wb_addr_next = {old_blk, OFFSET_BITS'(0)};
            end
            status_next = hit ? HIT_MAIN : (vhit_use ? HIT_VICTIM : HIT_MISS);
        end
        else if (state_reg == ST_EMIT)
        begin
            if (wb_pend_reg)
            begin
                wb_pend_next = 1'b0;
            end
            else
            begin
                fe_pend_next = 1'b0;
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!wb_pend_reg && !fe_pend_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            victim_enable_reg <= 1'b1;
            wb_pend_reg       <= 1'b0;
            fe_pend_reg       <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            wb_pend_reg <= wb_pend_next;
            fe_pend_reg <= fe_pend_next;
            if (cfg_wr_en)
            begin
                victim_enable_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        wb_addr_reg <= wb_addr_next;
        fe_addr_reg <= fe_addr_next;
        status_reg  <= status_next;
    end

    // result word: writeback, then fetch, then status
    always_comb
    begin
        rsp_valid = (state_reg == ST_EMIT);
        rsp       = '0;
        if (wb_pend_reg)
        begin
            rsp.kind        = KIND_WRITEBACK;
            rsp.mem_address = wb_addr_reg;
        end
        else if (fe_pend_reg)
        begin
            rsp.kind        = KIND_FETCH;
            rsp.mem_address = fe_addr_reg;
        end
        else
        begin
            rsp.kind       = KIND_STATUS;
            rsp.hit_status = status_reg;
            rsp.last       = 1'b1;
        end
    end

`ifndef SYNTH
    a_rsp_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> busy)
        else $error("result word outside an access");

    a_last_ends_access: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.last) |=> !busy)
        else $error("block still busy after status word");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy && !rsp_valid))
        else $error("accepted access not in lookup");

    a_hit_no_requests: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOKUP && hit) |=> (!wb_pend_reg && !fe_pend_reg))
        else $error("next-level request on a main hit");
`endif

endmodule
